>>> src/dsl_pkg.sv
// Shared constants, request codes and controller/datapath link types for the DAG sort core.
package dsl_pkg;

	localparam int MAX_NODES = 64;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int CNT_W     = $clog2(MAX_NODES + 1);
	localparam int FIELD_W   = 7;

	localparam logic [FIELD_W-1:0] NODE_COUNT_RST = 7'd64;

	// request codes carried on req_type
	localparam logic REQ_EDGE   = 1'b0;
	localparam logic REQ_FINISH = 1'b1;

	// commands from the controller to the datapath
	typedef struct packed {
		logic              load;
		logic              prep;
		logic              rd_row;
		logic [NODE_W-1:0] row;
		logic              pick;
		logic              apply;
		logic              finish;
	} dsl_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic              n_zero;
		logic [NODE_W-1:0] last_row;
		logic              any_ready;
	} dsl_stat_t;

endpackage

>>> src/dsl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module dsl_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port (read returns old data on a collision)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/dsl_ctrl.sv
// Controller state machine: sequences edge loading, in-degree count, sort and result word.
module dsl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              req_type,
	input  dsl_pkg::dsl_stat_t stat,
	output dsl_pkg::dsl_cmd_t  cmd,
	output logic              busy,
	output logic              done
);
	import dsl_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_PREP   = 7'b0000010,
		ST_INDEG  = 7'b0000100,
		ST_DRAIN  = 7'b0001000,
		ST_SELECT = 7'b0010000,
		ST_APPLY  = 7'b0100000,
		ST_RESULT = 7'b1000000
	} state_t;

	state_t            state_q;
	state_t            state_nxt;
	logic [NODE_W-1:0] row_q;

	// decode state into commands and next state
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.row   = row_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (req_type == REQ_FINISH) begin
						state_nxt = ST_PREP;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_PREP: begin
				cmd.prep  = 1'b1;
				state_nxt = stat.n_zero ? ST_RESULT : ST_INDEG;
			end
			ST_INDEG: begin
				cmd.rd_row = 1'b1;
				if (row_q == stat.last_row) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nxt = ST_SELECT;
			end
			ST_SELECT: begin
				if (stat.any_ready) begin
					cmd.pick  = 1'b1;
					state_nxt = ST_APPLY;
				end else begin
					state_nxt = ST_RESULT;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_nxt = ST_SELECT;
			end
			ST_RESULT: begin
				cmd.finish = 1'b1;
				state_nxt  = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// row counter for the in-degree sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (cmd.prep) begin
			row_q <= '0;
		end else if (cmd.rd_row) begin
			row_q <= row_q + NODE_W'(1);
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_RESULT);

endmodule

>>> src/dsl_dp.sv
// Datapath: adjacency matrix RAM, per-node in-degree and distance lanes, result counters.
module dsl_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dsl_pkg::dsl_cmd_t              cmd,
	input  logic [dsl_pkg::FIELD_W-1:0]    edge_from,
	input  logic [dsl_pkg::FIELD_W-1:0]    edge_to,
	input  logic                           cfg_wr_en,
	input  logic [dsl_pkg::FIELD_W-1:0]    cfg_wr_data,
	output dsl_pkg::dsl_stat_t             stat,
	output logic [dsl_pkg::FIELD_W-1:0]    source_count,
	output logic [dsl_pkg::FIELD_W-1:0]    longest_path
);
	import dsl_pkg::*;

	logic [FIELD_W-1:0]   node_count_q;
	logic [CNT_W-1:0]     n_eff;
	logic [MAX_NODES-1:0] act;

	logic                 ld_ok;
	logic [NODE_W-1:0]    ld_row;
	logic                 ld_s1;
	logic [NODE_W-1:0]    ld_row_s1;
	logic [NODE_W-1:0]    ld_col_s1;
	logic [MAX_NODES-1:0] col_bit;

	logic [MAX_NODES-1:0] row_valid_q;
	logic                 fwd_vld_q;
	logic [NODE_W-1:0]    fwd_row_q;
	logic [MAX_NODES-1:0] fwd_data_q;

	logic [NODE_W-1:0]    raddr;
	logic [NODE_W-1:0]    rd_row_s1;
	logic                 rd_vld_s1;
	logic [MAX_NODES-1:0] ram_rdata;
	logic [MAX_NODES-1:0] rdat;
	logic [MAX_NODES-1:0] mrow;
	logic [MAX_NODES-1:0] wdata;

	logic                 acc_s1;
	logic [CNT_W-1:0]     indeg_q [MAX_NODES];
	logic [CNT_W-1:0]     dist_q  [MAX_NODES];
	logic [MAX_NODES-1:0] done_q;
	logic [MAX_NODES-1:0] ready;
	logic [NODE_W-1:0]    pick_v;
	logic [CNT_W-1:0]     pv_s1;
	logic [CNT_W-1:0]     src_q;
	logic [CNT_W-1:0]     long_q;

	// lowest set bit of a node vector
	function automatic logic [NODE_W-1:0] lowest_set(input logic [MAX_NODES-1:0] v);
		logic [NODE_W-1:0] idx;
		idx = '0;
		for (int j = MAX_NODES - 1; j >= 0; j--) begin
			if (v[j]) begin
				idx = NODE_W'(j);
			end
		end
		return idx;
	endfunction

	// node count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
		end else if (cfg_wr_en) begin
			node_count_q <= cfg_wr_data;
		end
	end

	// clamp node count and build the active-node mask
	always_comb begin
		if (int'(node_count_q) > MAX_NODES) begin
			n_eff = CNT_W'(MAX_NODES);
		end else begin
			n_eff = CNT_W'(node_count_q);
		end
		for (int j = 0; j < MAX_NODES; j++) begin
			act[j] = (CNT_W'(j) < n_eff);
		end
	end

	assign stat.n_zero   = (n_eff == '0);
	assign stat.last_row = NODE_W'(n_eff - CNT_W'(1));

	// range check an incoming edge word
	assign ld_ok  = cmd.load && (edge_from != '0) && (edge_to != '0) &&
	                (int'(edge_from) <= int'(n_eff)) && (int'(edge_to) <= int'(n_eff));
	assign ld_row = NODE_W'(edge_from - FIELD_W'(1));

	// ready set and lowest ready node
	always_comb begin
		for (int j = 0; j < MAX_NODES; j++) begin
			ready[j] = act[j] && !done_q[j] && (indeg_q[j] == '0);
		end
	end
	assign pick_v         = lowest_set(ready);
	assign stat.any_ready = |ready;

	// select read row: edge load, in-degree sweep, or picked node
	always_comb begin
		if (cmd.load) begin
			raddr = ld_row;
		end else if (cmd.rd_row) begin
			raddr = cmd.row;
		end else begin
			raddr = pick_v;
		end
	end

	// row fetch with forwarding of the last write and invalid rows reading as zero
	always_comb begin
		if (fwd_vld_q && (fwd_row_q == rd_row_s1)) begin
			rdat = fwd_data_q;
		end else if (rd_vld_s1) begin
			rdat = ram_rdata;
		end else begin
			rdat = '0;
		end
		mrow             = rdat & act;
		col_bit          = '0;
		col_bit[ld_col_s1] = 1'b1;
		wdata            = rdat | col_bit;
	end

	dsl_ram #(
		.WIDTH(MAX_NODES),
		.DEPTH(MAX_NODES)
	) u_adj_ram (
		.clk  (clk),
		.we   (ld_s1),
		.waddr(ld_row_s1),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// read tracking and edge stage payload
	always_ff @(posedge clk) begin
		rd_row_s1 <= raddr;
		rd_vld_s1 <= row_valid_q[raddr];
		ld_row_s1 <= ld_row;
		ld_col_s1 <= NODE_W'(edge_to - FIELD_W'(1));
	end

	// stage flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_s1  <= 1'b0;
			acc_s1 <= 1'b0;
		end else begin
			ld_s1  <= ld_ok;
			acc_s1 <= cmd.rd_row;
		end
	end

	// row valid bits and write forwarding; drop everything after a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			fwd_vld_q   <= 1'b0;
		end else if (cmd.finish) begin
			row_valid_q <= '0;
			fwd_vld_q   <= 1'b0;
		end else if (ld_s1) begin
			row_valid_q[ld_row_s1] <= 1'b1;
			fwd_vld_q              <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			fwd_row_q  <= ld_row_s1;
			fwd_data_q <= wdata;
		end
	end

	// per-node lanes: count in-degrees, then remove edges and relax distances
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			for (int j = 0; j < MAX_NODES; j++) begin
				indeg_q[j] <= '0;
				dist_q[j]  <= '0;
			end
			done_q <= '0;
		end else if (acc_s1) begin
			for (int j = 0; j < MAX_NODES; j++) begin
				if (mrow[j]) begin
					indeg_q[j] <= indeg_q[j] + CNT_W'(1);
				end
			end
		end else if (cmd.apply) begin
			for (int j = 0; j < MAX_NODES; j++) begin
				if (mrow[j] && (indeg_q[j] != '0)) begin
					indeg_q[j] <= indeg_q[j] - CNT_W'(1);
				end
				if (mrow[j] && (pv_s1 > dist_q[j])) begin
					dist_q[j] <= pv_s1;
				end
			end
		end else if (cmd.pick) begin
			done_q[pick_v] <= 1'b1;
		end
	end

	// path length of the picked node
	always_ff @(posedge clk) begin
		if (cmd.pick) begin
			pv_s1 <= dist_q[pick_v] + CNT_W'(1);
		end
	end

	// source count and longest path to a sink
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q  <= '0;
			long_q <= '0;
		end else if (cmd.prep) begin
			src_q  <= '0;
			long_q <= '0;
		end else if (cmd.pick) begin
			if (dist_q[pick_v] == '0) begin
				src_q <= src_q + CNT_W'(1);
			end
		end else if (cmd.apply) begin
			if ((mrow == '0) && (pv_s1 > long_q)) begin
				long_q <= pv_s1;
			end
		end
	end

	assign source_count = FIELD_W'(src_q);
	assign longest_path = FIELD_W'(long_q);

endmodule

>>> src/dag_sources_and_longest_path_core.sv
// Top level of the DAG source-count and longest-path core.
// Edge words (req_type 0) are taken one per clock and busy stays low while edges load;
// an edge with an endpoint of 0 or above node_count (clamped to 64) is dropped, a repeated
// edge is kept once. A finish word (req_type 1) raises busy and runs the sort: a setup
// state, a sweep over the adjacency rows to count in-degrees and a drain state to take in
// the last row, then for each node that the topological order reaches a select from the
// ready set and an apply of its row, a last select that sees the ready set empty, and the
// result state; with node_count 0 the setup state goes straight to the result. The
// adjacency RAM has a single row read port, so the sweep reads one row at a time. done
// pulses for exactly one cycle with source_count and longest_path; the receiver cannot
// hold it off. The graph is then empty again and node_count is kept.
// node_count may only be written while busy is low and no edge word was taken in that cycle.
module dag_sources_and_longest_path_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        req_type,
	input  logic [dsl_pkg::FIELD_W-1:0] edge_from,
	input  logic [dsl_pkg::FIELD_W-1:0] edge_to,
	input  logic                        cfg_wr_en,
	input  logic [dsl_pkg::FIELD_W-1:0] cfg_wr_data,
	output logic                        done,
	output logic [dsl_pkg::FIELD_W-1:0] source_count,
	output logic [dsl_pkg::FIELD_W-1:0] longest_path
);
	import dsl_pkg::*;

	dsl_cmd_t  cmd;
	dsl_stat_t stat;

	dsl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req_type(req_type),
		.stat    (stat),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done)
	);

	dsl_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.edge_from   (edge_from),
		.edge_to     (edge_to),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.stat        (stat),
		.source_count(source_count),
		.longest_path(longest_path)
	);

endmodule

>>> tb/sv/dsl_result_checker.sv
// Watches the DAG sort core ports, predicts each finish answer and compares it with the result.
`timescale 1ns / 1ps

module dsl_result_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic                        req_type,
	input  logic [dsl_pkg::FIELD_W-1:0] edge_from,
	input  logic [dsl_pkg::FIELD_W-1:0] edge_to,
	input  logic                        cfg_wr_en,
	input  logic [dsl_pkg::FIELD_W-1:0] cfg_wr_data,
	input  logic                        done,
	input  logic [dsl_pkg::FIELD_W-1:0] source_count,
	input  logic [dsl_pkg::FIELD_W-1:0] longest_path,
	output int                          fail_count,
	output int                          pending
);
	import dsl_pkg::*;

	typedef struct packed {
		logic [FIELD_W-1:0] sources;
		logic [FIELD_W-1:0] longest;
	} answer_t;

	localparam int unsigned FIELD_TOP = (1 << FIELD_W) - 1;

	logic [MAX_NODES-1:0] link_row [MAX_NODES];
	logic [FIELD_W-1:0]   node_cnt;
	answer_t              pending_answers [$];

	// nodes in use: anything above the matrix size acts as the full matrix
	function automatic int unsigned nodes_in_use();
		if (node_cnt > MAX_NODES)
			return MAX_NODES;
		return 32'(node_cnt);
	endfunction

	function automatic logic [FIELD_W-1:0] clip_field(int unsigned v);
		return (v > FIELD_TOP) ? FIELD_TOP[FIELD_W-1:0] : v[FIELD_W-1:0];
	endfunction

	task automatic clear_graph();
		for (int i = 0; i < MAX_NODES; i++)
			link_row[i] = '0;
	endtask

	// store one link, dropping endpoints of 0 or beyond the nodes in use
	task automatic add_link(logic [FIELD_W-1:0] f, logic [FIELD_W-1:0] t);
		int unsigned n;
		n = nodes_in_use();
		if (f >= 1 && t >= 1 && f <= n && t <= n)
			link_row[NODE_W'(f - FIELD_W'(1))][NODE_W'(t - FIELD_W'(1))] = 1'b1;
	endtask

	// Kahn order over the stored links, then longest node count ending at a sink
	function automatic answer_t count_sources_and_depth();
		int unsigned n, head, tail, sources, longest, best, v;
		int unsigned indeg [MAX_NODES];
		bit          succ [MAX_NODES];
		int unsigned depth [MAX_NODES];
		int unsigned order [MAX_NODES];
		answer_t     a;
		n = nodes_in_use();
		for (int i = 0; i < MAX_NODES; i++) begin
			indeg[i] = 0;
			succ[i]  = 0;
			depth[i] = 0;
			order[i] = 0;
		end
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++)
				if (link_row[i][j]) begin
					succ[i] = 1;
					indeg[j]++;
				end
		tail = 0;
		for (int i = 0; i < n; i++)
			if (indeg[i] == 0) begin
				order[tail] = i;
				tail++;
			end
		sources = tail;
		head = 0;
		while (head < tail) begin
			v = order[head];
			for (int j = 0; j < n; j++)
				if (link_row[v][j] && indeg[j] != 0) begin
					indeg[j]--;
					if (indeg[j] == 0) begin
						order[tail] = j;
						tail++;
					end
				end
			head++;
		end
		for (int k = 0; k < tail; k++) begin
			v = order[k];
			best = 0;
			for (int j = 0; j < n; j++)
				if (link_row[j][v] && depth[j] > best)
					best = depth[j];
			depth[v] = best + 1;
		end
		longest = 0;
		for (int i = 0; i < n; i++)
			if (!succ[i] && depth[i] > longest)
				longest = depth[i];
		a.sources = clip_field(sources);
		a.longest = clip_field(longest);
		return a;
	endfunction

	// compare results first, then take configuration and the accepted word
	always @(posedge clk) begin : watch
		answer_t want;
		if (!arst_n) begin
			clear_graph();
			node_cnt = NODE_COUNT_RST;
			pending_answers.delete();
		end else begin
			if (done) begin
				if (pending_answers.size() == 0) begin
					$error("unexpected result: source_count %0d, longest_path %0d",
						source_count, longest_path);
					fail_count++;
				end else begin
					want = pending_answers.pop_front();
					if (source_count !== want.sources) begin
						$error("source_count: expected %0d, actual %0d", want.sources,
							source_count);
						fail_count++;
					end
					if (longest_path !== want.longest) begin
						$error("longest_path: expected %0d, actual %0d", want.longest,
							longest_path);
						fail_count++;
					end
				end
			end
			if (cfg_wr_en)
				node_cnt = cfg_wr_data;
			if (start && !busy) begin
				if (req_type == REQ_EDGE) begin
					add_link(edge_from, edge_to);
				end else begin
					pending_answers.push_back(count_sources_and_depth());
					clear_graph();
				end
			end
		end
		pending = pending_answers.size();
	end

endmodule

>>> tb/sv/tb_dag_sources_and_longest_path_core.sv
// Stimulus and verdict for the DAG source-count and longest-path core.
`timescale 1ns / 1ps

module tb_dag_sources_and_longest_path_core;
	import dsl_pkg::*;

	localparam int ITEMS       = 1550;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE      = 3 * MAX_NODES + 8;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               start       = 1'b0;
	logic               req_type    = REQ_EDGE;
	logic [FIELD_W-1:0] edge_from   = '0;
	logic [FIELD_W-1:0] edge_to     = '0;
	logic               cfg_wr_en   = 1'b0;
	logic [FIELD_W-1:0] cfg_wr_data = '0;
	logic               busy;
	logic               done;
	logic [FIELD_W-1:0] source_count;
	logic [FIELD_W-1:0] longest_path;
	int                 fail_count;
	int                 pending;
	int                 cycles = 0;
	bit                 steady = 0;

	dag_sources_and_longest_path_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.edge_from    (edge_from),
		.edge_to      (edge_to),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.done         (done),
		.source_count (source_count),
		.longest_path (longest_path)
	);

	dsl_result_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.edge_from    (edge_from),
		.edge_to      (edge_to),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.done         (done),
		.source_count (source_count),
		.longest_path (longest_path),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Entered and left at a falling edge; start stays high between back-to-back words.
	task automatic put_word(logic t, logic [FIELD_W-1:0] f, logic [FIELD_W-1:0] d);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start     <= 1'b1;
		req_type  <= t;
		edge_from <= f;
		edge_to   <= d;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	// hold off until the core is idle and drained, then write node_count
	task automatic set_node_count(logic [FIELD_W-1:0] v);
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0 || busy)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	initial begin : stimulus
		int n_cfg, n, kind, count, mid, words_sent, i, j, pick, tmp;
		int perm [MAX_NODES];
		logic [FIELD_W-1:0] f, t, last_f, last_t;
		bit noise;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// empty graph at the reset node count, then the endpoint extremes
		put_word(REQ_FINISH, '0, '0);
		put_word(REQ_EDGE, 7'd64, 7'd1);
		put_word(REQ_EDGE, 7'd1, 7'd64);
		put_word(REQ_EDGE, 7'd1, 7'd64);
		put_word(REQ_EDGE, 7'd0, 7'd5);
		put_word(REQ_EDGE, 7'd5, 7'd0);
		put_word(REQ_EDGE, 7'd127, 7'd3);
		put_word(REQ_EDGE, 7'd3, 7'd127);
		put_word(REQ_EDGE, 7'd65, 7'd2);
		put_word(REQ_EDGE, 7'd7, 7'd7);
		put_word(REQ_FINISH, 7'd127, 7'd127);

		// no nodes at all
		set_node_count(7'd0);
		put_word(REQ_EDGE, 7'd1, 7'd1);
		put_word(REQ_FINISH, '0, '0);

		// single node on a self loop
		set_node_count(7'd1);
		put_word(REQ_EDGE, 7'd1, 7'd1);
		put_word(REQ_FINISH, '0, '0);

		// oversize count, a cycle with a node behind it, count shrunk while loading
		set_node_count(7'd127);
		put_word(REQ_EDGE, 7'd64, 7'd63);
		put_word(REQ_EDGE, 7'd1, 7'd2);
		put_word(REQ_EDGE, 7'd2, 7'd3);
		put_word(REQ_EDGE, 7'd3, 7'd2);
		put_word(REQ_EDGE, 7'd3, 7'd4);
		set_node_count(7'd5);
		put_word(REQ_EDGE, 7'd4, 7'd5);
		put_word(REQ_FINISH, '0, '0);

		// random graphs, mostly acyclic under a shuffled labelling
		words_sent = 0;
		last_f = 7'd1;
		last_t = 7'd2;
		while (words_sent < ITEMS) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				n_cfg = 0;
			else if (pick == 1)
				n_cfg = 1;
			else if (pick == 2)
				n_cfg = MAX_NODES;
			else if (pick == 3)
				n_cfg = $urandom_range(MAX_NODES + 1, 127);
			else if (pick < 8)
				n_cfg = $urandom_range(17, MAX_NODES);
			else
				n_cfg = $urandom_range(2, 16);
			set_node_count(n_cfg[FIELD_W-1:0]);
			n = (n_cfg > MAX_NODES) ? MAX_NODES : n_cfg;
			steady = ($urandom_range(0, 3) == 0);

			for (i = 0; i < n; i++)
				perm[i] = i + 1;
			for (i = n - 1; i > 0; i--) begin
				j = $urandom_range(0, i);
				tmp = perm[i];
				perm[i] = perm[j];
				perm[j] = tmp;
			end

			kind  = $urandom_range(0, 9);
			count = (n == 0) ? $urandom_range(0, 4) : $urandom_range(0, (3 * n > 60) ? 60 : 3 * n);
			mid   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, count) : -1;

			for (int e = 0; e < count; e++) begin
				// change the node count part-way through loading
				if (e == mid)
					set_node_count(FIELD_W'($urandom_range(0, MAX_NODES)));
				noise = (kind == 9) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 11) == 0);
				if (noise || n < 2) begin
					pick = $urandom_range(0, 4);
					if (pick == 0) begin
						f = '0;
						t = FIELD_W'($urandom_range(0, 127));
					end else if (pick == 1) begin
						f = FIELD_W'($urandom_range(n + 1, 127));
						t = FIELD_W'($urandom_range(0, 127));
					end else if (pick == 2) begin
						f = FIELD_W'($urandom_range(0, 127));
						t = FIELD_W'($urandom_range(n + 1, 127));
					end else if (pick == 3) begin
						f = FIELD_W'($urandom_range(1, (n < 1) ? 1 : n));
						t = f;
					end else begin
						f = last_f;
						t = last_t;
					end
				end else if (kind < 7) begin
					i = $urandom_range(0, n - 2);
					j = ($urandom_range(0, 1) == 1) ? i + 1 : $urandom_range(i + 1, n - 1);
					f = FIELD_W'(perm[i]);
					t = FIELD_W'(perm[j]);
				end else begin
					f = FIELD_W'($urandom_range(1, n));
					t = FIELD_W'($urandom_range(1, n));
				end
				put_word(REQ_EDGE, f, t);
				last_f = f;
				last_t = t;
				words_sent++;
			end
			put_word(REQ_FINISH, FIELD_W'($urandom_range(0, 127)),
				FIELD_W'($urandom_range(0, 127)));
			words_sent++;
		end

		// drain, let the core settle, then give the verdict
		steady = 0;
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0 || busy)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> dag_sources_and_longest_path_core.f
src/dsl_pkg.sv
src/dsl_ram.sv
src/dsl_ctrl.sv
src/dsl_dp.sv
src/dag_sources_and_longest_path_core.sv
tb/sv/dsl_result_checker.sv
tb/sv/tb_dag_sources_and_longest_path_core.sv
